/* design/pif_pkg.sv */
`default_nettype none

package pif_pkg;

   // table geometry
   localparam int MAX_SLOTS   = 16;
   localparam int TABLE_DEPTH = MAX_SLOTS + 2;
   localparam int TIDX_W      = $clog2(TABLE_DEPTH);
   localparam int NCNT_W      = $clog2(MAX_SLOTS + 1);

   // field widths
   localparam int OP_W     = 1;
   localparam int IDX_W    = 5;
   localparam int TIME_W   = 33;
   localparam int QUERY_W  = 48;
   localparam int PERIOD_W = 32;
   localparam int NSLOT_W  = 5;
   localparam int SLOT_W   = 4;
   localparam int WGT_W    = 17;
   localparam int FRAC_W   = 16;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = $clog2(QUERY_W);

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 48;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SLOTS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD    = 1'b1;

   localparam logic [NSLOT_W-1:0]  NUM_SLOTS_RST = 5'd12;
   localparam logic [PERIOD_W-1:0] PERIOD_RST    = 32'd65536;

   localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

   // opcodes
   localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
   localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BELOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ABOVE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd3;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MOD  = 9'b000000010,
      S_RD0  = 9'b000000100,
      S_RDL  = 9'b000001000,
      S_CHK  = 9'b000010000,
      S_SCAN = 9'b000100000,
      S_DIVI = 9'b001000000,
      S_DIV  = 9'b010000000,
      S_FIN  = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

/* design/pif_ram.sv */
`default_nettype none

module pif_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 18,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/periodic_interp_factor_top.sv */
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser op; tdata index, entry time, query time
// rsp      out        rsp_tvalid/rsp_tready  tuser status; tdata slots and weights
// csr      in         csr_wr_en              csr_addr, csr_wdata
//
// A table write leaves the block idle, ready for the next beat. A query runs
// through the bit-serial floor modulo of the query time, the reads and checks
// of the table ends, one table read per interval scanned (up to n+1), a set-up
// step and the bit-serial weight divide, and a load of the output register;
// the block then returns to idle to take the next beat.
// Table reads go through one memory read port.
// Reset is synchronous and clears control and configuration; table entries
// are undefined until written. The result sits in an output register, so
// the next item is taken while it waits; a query ready to finish holds until
// that register is free.
`default_nettype none

module periodic_interp_factor_top
   import pif_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // entry_index[4:0], entry_time[37:5], query_time[85:38], zero pad
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   // op[0]
   input  wire logic [OP_W-1:0]         req_tuser,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // first_slot[3:0], second_slot[7:4], first_weight[24:8],
   // second_weight[41:25], zero pad
   output logic      [RSP_DATA_W-1:0]   rsp_tdata,
   // status[1:0]
   output logic      [STATUS_W-1:0]     rsp_tuser,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]    csr_addr,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   // unpack the request beat
   logic [IDX_W-1:0]   req_entry_index;
   logic [TIME_W-1:0]  req_entry_time;
   logic [QUERY_W-1:0] req_query_time;

   assign req_entry_index = req_tdata[IDX_W-1:0];
   assign req_entry_time  = req_tdata[IDX_W +: TIME_W];
   assign req_query_time  = req_tdata[IDX_W+TIME_W +: QUERY_W];

   // control and configuration
   state_type             state_ff, state_in;
   logic                  out_valid_ff, out_valid_in;
   logic [NSLOT_W-1:0]    num_slots_ff, num_slots_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;

   // working registers
   logic [NCNT_W-1:0]     n_ff, n_in;
   logic [PERIOD_W-1:0]   p_ff, p_in;
   logic                  neg_ff, neg_in;
   logic [QUERY_W-1:0]    qabs_ff, qabs_in;
   logic [PERIOD_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [PERIOD_W-1:0]   t_ff, t_in;
   logic [TIME_W-1:0]     tab0_ff, tab0_in;
   logic [TIME_W-1:0]     prev_ff, prev_in;
   logic [TIME_W-1:0]     tlo_ff, tlo_in;
   logic [TIME_W-1:0]     thi_ff, thi_in;
   logic [TIDX_W-1:0]     i_ff, i_in;
   logic [TIDX_W-1:0]     lo_ff, lo_in;
   logic [TIME_W-1:0]     den_ff, den_in;
   logic [TIME_W-1:0]     div_r_ff, div_r_in;
   logic [WGT_W-1:0]      w0_ff, w0_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff, rsp_user_in;

   // table memory
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [TIDX_W-1:0]     ram_rd_addr;
   logic [TIME_W-1:0]     ram_rd_data;

   pif_ram #(
      .WIDTH (TIME_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (TIDX_W'(req_entry_index)),
      .wr_data (req_entry_time),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   logic                  req_fire;
   logic [PERIOD_W:0]     mod_shift;
   logic [PERIOD_W:0]     mod_diff;
   logic [TIME_W:0]       div_shift;
   logic [TIME_W:0]       div_diff;
   logic [TIME_W-1:0]     num_w;
   logic [TIME_W-1:0]     den_w;
   logic [SLOT_W-1:0]     s0_w, s1_w;
   logic [WGT_W-1:0]      w1_w;
   logic                  ok_w;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign mod_shift = {rem_ff, qabs_ff[QUERY_W-1]};
   assign mod_diff  = mod_shift - {1'b0, p_ff};
   assign div_shift = {div_r_ff, 1'b0};
   assign div_diff  = div_shift - {1'b0, den_ff};
   assign num_w     = thi_ff - {1'b0, t_ff};
   assign den_w     = thi_ff - tlo_ff;

   // periodic slot indices of the bracketing interval
   assign s0_w = (lo_ff == '0) ? SLOT_W'(n_ff - NCNT_W'(1))
                               : SLOT_W'(lo_ff - TIDX_W'(1));
   assign s1_w = (NCNT_W'(s0_w) == n_ff - NCNT_W'(1)) ? '0 : s0_w + SLOT_W'(1);
   assign w1_w = ONE_Q16 - w0_ff;
   assign ok_w = (status_ff == ST_OK);

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      num_slots_in = num_slots_ff;
      period_in    = period_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      neg_in       = neg_ff;
      qabs_in      = qabs_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      t_in         = t_ff;
      tab0_in      = tab0_ff;
      prev_in      = prev_ff;
      tlo_in       = tlo_ff;
      thi_in       = thi_ff;
      i_in         = i_ff;
      lo_in        = lo_ff;
      den_in       = den_ff;
      div_r_in     = div_r_ff;
      w0_in        = w0_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_NUM_SLOTS: num_slots_in = csr_wdata[NSLOT_W-1:0];
            CSR_PERIOD:    period_in    = csr_wdata[PERIOD_W-1:0];
            default:       ;
         endcase
      end

      // drop the result once the beat is taken
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_WRITE) begin
                  ram_wr_en = (int'(req_entry_index) < TABLE_DEPTH);
               end else begin
                  if (num_slots_ff == '0) begin
                     n_in = NCNT_W'(1);
                  end else if (int'(num_slots_ff) > MAX_SLOTS) begin
                     n_in = NCNT_W'(MAX_SLOTS);
                  end else begin
                     n_in = NCNT_W'(num_slots_ff);
                  end
                  p_in      = period_ff;
                  neg_in    = req_query_time[QUERY_W-1];
                  qabs_in   = req_query_time[QUERY_W-1] ? (~req_query_time + QUERY_W'(1))
                                                        : req_query_time;
                  rem_in    = '0;
                  cnt_in    = '0;
                  status_in = ST_OK;
                  w0_in     = '0;
                  lo_in     = '0;
                  state_in  = S_MOD;
               end
            end
         end

         // one remainder bit per cycle, magnitude first
         S_MOD: begin
            rem_in  = mod_shift[PERIOD_W] || !mod_diff[PERIOD_W] ? mod_diff[PERIOD_W-1:0]
                                                                 : mod_shift[PERIOD_W-1:0];
            qabs_in = {qabs_ff[QUERY_W-2:0], 1'b0};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(QUERY_W - 1)) begin
               state_in = S_RD0;
            end
         end

         // floor correction, fetch the first entry
         S_RD0: begin
            if (p_ff == '0) begin
               t_in = '0;
            end else if (neg_ff && (rem_ff != '0)) begin
               t_in = p_ff - rem_ff;
            end else begin
               t_in = rem_ff;
            end
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            state_in    = S_RDL;
         end

         S_RDL: begin
            tab0_in     = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = TIDX_W'(n_ff) + TIDX_W'(1);
            state_in    = S_CHK;
         end

         S_CHK: begin
            if ({1'b0, t_ff} < tab0_ff) begin
               status_in = ST_BELOW;
               state_in  = S_FIN;
            end else if ({1'b0, t_ff} > ram_rd_data) begin
               status_in = ST_ABOVE;
               state_in  = S_FIN;
            end else begin
               prev_in     = tab0_ff;
               i_in        = '0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = TIDX_W'(1);
               state_in    = S_SCAN;
            end
         end

         // compare entry i (held) with entry i+1 (just read)
         S_SCAN: begin
            if (((prev_ff <= {1'b0, t_ff}) && (ram_rd_data > {1'b0, t_ff}))
                || (i_ff == TIDX_W'(n_ff))) begin
               lo_in    = i_ff;
               tlo_in   = prev_ff;
               thi_in   = ram_rd_data;
               state_in = S_DIVI;
            end else begin
               prev_in     = ram_rd_data;
               i_in        = i_ff + TIDX_W'(1);
               ram_rd_en   = 1'b1;
               ram_rd_addr = i_ff + TIDX_W'(2);
            end
         end

         S_DIVI: begin
            den_in   = den_w;
            div_r_in = num_w;
            cnt_in   = '0;
            if (thi_ff <= tlo_ff) begin
               status_in = ST_ZERO;
               state_in  = S_FIN;
            end else if (num_w >= den_w) begin
               // weight of one or more saturates
               w0_in    = ONE_Q16;
               state_in = S_FIN;
            end else begin
               state_in = S_DIV;
            end
         end

         // restoring divide, one quotient bit per cycle
         S_DIV: begin
            if (!div_diff[TIME_W]) begin
               div_r_in = div_diff[TIME_W-1:0];
               w0_in    = {w0_ff[WGT_W-2:0], 1'b1};
            end else begin
               div_r_in = div_shift[TIME_W-1:0];
               w0_in    = {w0_ff[WGT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
               state_in = S_FIN;
            end
         end

         // hold until the output register is free
         S_FIN: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = '0;
               if (ok_w) begin
                  rsp_data_in[SLOT_W-1:0]             = s0_w;
                  rsp_data_in[SLOT_W +: SLOT_W]       = s1_w;
                  rsp_data_in[2*SLOT_W +: WGT_W]      = w0_ff;
                  rsp_data_in[2*SLOT_W+WGT_W +: WGT_W] = w1_w;
               end
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         num_slots_ff <= NUM_SLOTS_RST;
         period_ff    <= PERIOD_RST;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         num_slots_ff <= num_slots_in;
         period_ff    <= period_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      p_ff        <= p_in;
      neg_ff      <= neg_in;
      qabs_ff     <= qabs_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      t_ff        <= t_in;
      tab0_ff     <= tab0_in;
      prev_ff     <= prev_in;
      tlo_ff      <= tlo_in;
      thi_ff      <= thi_in;
      i_ff        <= i_in;
      lo_ff       <= lo_in;
      den_ff      <= den_in;
      div_r_ff    <= div_r_in;
      w0_ff       <= w0_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire

/* design/pif_checker.sv */
`default_nettype none

module pif_checker
   import pif_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic [STATUS_W-1:0]   rsp_tuser
);

   logic [SLOT_W-1:0] s0;
   logic [SLOT_W-1:0] s1;
   logic [WGT_W-1:0]  w0;
   logic [WGT_W-1:0]  w1;

   assign s0 = rsp_tdata[SLOT_W-1:0];
   assign s1 = rsp_tdata[SLOT_W +: SLOT_W];
   assign w0 = rsp_tdata[2*SLOT_W +: WGT_W];
   assign w1 = rsp_tdata[2*SLOT_W+WGT_W +: WGT_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata == '0))
      else $error("fault status with nonzero slots or weights");

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_OK) |-> (w0 <= ONE_Q16) && (w0 + w1 == ONE_Q16))
      else $error("weights do not sum to one");

   a_slot_next: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_OK) |-> (s1 == '0) || (s1 == s0 + SLOT_W'(1)))
      else $error("second slot does not follow first slot");

endmodule

bind periodic_interp_factor_top pif_checker u_pif_checker (.*);

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import pif_pkg::*;

   localparam int  CYCLE_LIMIT  = 1000000;
   localparam int  DRAIN_CYCLES = 120;
   localparam int  NUM_PHASES   = 12;
   localparam int  PHASE_ITEMS  = 105;
   localparam int  LONG_HOLD    = 600;
   localparam int  TIME_LSB     = IDX_W;
   localparam int  QUERY_LSB    = IDX_W + TIME_W;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [SLOT_W-1:0]   s0;
      logic [SLOT_W-1:0]   s1;
      logic [WGT_W-1:0]    w0;
      logic [WGT_W-1:0]    w1;
      logic [STATUS_W-1:0] st;
   } interp_res_type;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [IDX_W-1:0]   idx;
      logic [TIME_W-1:0]  etime;
      logic [QUERY_W-1:0] qtime;
   } req_item_type;

   // ascending from zero, ascending from an offset, random entries,
   // ascending with repeated entries
   typedef enum int {
      TK_ASCEND,
      TK_OFFSET,
      TK_RANDOM,
      TK_REPEAT
   } tbl_kind_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [OP_W-1:0]         req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_addr = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // predictor state, updated on accepted beats and register writes
   logic [NSLOT_W-1:0]  cfg_slots  = NUM_SLOTS_RST;
   logic [PERIOD_W-1:0] cfg_period = PERIOD_RST;
   logic [TIME_W-1:0]   tbl_now  [TABLE_DEPTH];
   // table as the stimulus generator has queued it
   logic [TIME_W-1:0]   plan_tbl [TABLE_DEPTH];

   req_item_type   pending_q[$];
   interp_res_type weight_q[$];
   req_item_type   drv_item;

   int  errors = 0;
   int  n_writes = 0;
   int  n_queries = 0;
   int  st_cnt [4];
   int  burst_left = 0;
   int  gap_left = 0;
   int  ready_run = 0;
   int  hold_cnt = 0;
   bit  hold_done = 1'b0;
   bit  long_hold_go = 1'b0;
   int  cycle_cnt = 0;

   periodic_interp_factor_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned eff_slots();
      if (cfg_slots == 0) return 1;
      if (cfg_slots > MAX_SLOTS) return MAX_SLOTS;
      return cfg_slots;
   endfunction

   function automatic interp_res_type interp_predict(logic [QUERY_W-1:0] qt);
      interp_res_type r;
      int unsigned    n, m, lo, hi, i;
      longint         sq, p, rem;
      logic [63:0]    t, num, den, quo;
      bit             found;
      r     = '0;
      found = 1'b0;
      n     = eff_slots();
      m     = n + 2;
      sq    = longint'($signed(qt));
      if (cfg_period == 0) begin
         t = 64'd0;
      end else begin
         p   = longint'({32'd0, cfg_period});
         rem = sq % p;
         if (rem < 0) rem = rem + p;
         t = rem;
      end
      if (t < tbl_now[0]) begin
         r.st = ST_BELOW;
         return r;
      end
      if (t > tbl_now[m-1]) begin
         r.st = ST_ABOVE;
         return r;
      end
      lo = m - 1;
      for (i = 0; i + 1 < m; i++) begin
         if (!found && tbl_now[i] <= t && tbl_now[i+1] > t) begin
            lo    = i;
            found = 1'b1;
         end
      end
      if (lo > n) lo = n;
      hi = lo + 1;
      if (tbl_now[hi] <= tbl_now[lo]) begin
         r.st = ST_ZERO;
         return r;
      end
      den  = tbl_now[hi] - tbl_now[lo];
      num  = tbl_now[hi] - t;
      quo  = (num << FRAC_W) / den;
      r.w0 = (quo > ONE_Q16) ? ONE_Q16 : quo[WGT_W-1:0];
      r.w1 = ONE_Q16 - r.w0;
      r.s0 = (lo == 0) ? n - 1 : lo - 1;
      r.s1 = (r.s0 == n - 1) ? 0 : r.s0 + 1;
      r.st = ST_OK;
      return r;
   endfunction

   // driver: bursts of beats with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            gap_left   <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            drv_item = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= drv_item.op;
            req_tdata  <= {2'b00, drv_item.qtime, drv_item.etime, drv_item.idx};
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: own stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_run  <= 0;
         hold_cnt   <= 0;
         hold_done  <= 1'b0;
      end else if (hold_cnt != 0) begin
         rsp_tready <= 1'b0;
         hold_cnt   <= hold_cnt - 1;
      end else if (long_hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_cnt   <= LONG_HOLD;
         hold_done  <= 1'b1;
      end else if (ready_run != 0) begin
         ready_run <= ready_run - 1;
      end else if (rsp_tready) begin
         rsp_tready <= 1'b0;
         ready_run  <= $urandom_range(0, 9);
      end else begin
         rsp_tready <= 1'b1;
         ready_run  <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                   : $urandom_range(0, 20);
      end
   end

   // update the table on every accepted write beat, predict on every accepted query beat
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         if (req_tuser == OP_WRITE) begin
            if (req_tdata[IDX_W-1:0] < TABLE_DEPTH)
               tbl_now[req_tdata[IDX_W-1:0]] = req_tdata[TIME_LSB +: TIME_W];
            n_writes++;
         end else begin
            weight_q.push_back(interp_predict(req_tdata[QUERY_LSB +: QUERY_W]));
            n_queries++;
         end
      end
   end

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d got %0d", $time, what, want, got);
         errors++;
      end
   endtask

   // compare every accepted result beat with the oldest prediction
   always @(posedge clock) begin
      interp_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (weight_q.size() == 0) begin
            $display("%0t: result with nothing expected, tdata %h tuser %0d",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = weight_q.pop_front();
            check_field("first_slot", want.s0, rsp_tdata[3:0]);
            check_field("second_slot", want.s1, rsp_tdata[7:4]);
            check_field("first_weight", want.w0, rsp_tdata[24:8]);
            check_field("second_weight", want.w1, rsp_tdata[41:25]);
            check_field("status", want.st, rsp_tuser);
            st_cnt[rsp_tuser]++;
         end
      end
   end

   initial begin
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, weight_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic csr_write(logic [CSR_IDX_W-1:0] a, logic [CSR_DATA_W-1:0] d);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (a == CSR_NUM_SLOTS) cfg_slots = d[NSLOT_W-1:0];
      else cfg_period = d;
   endtask

   task automatic queue_write(int unsigned idx, logic [TIME_W-1:0] tv);
      req_item_type it;
      it.op    = OP_WRITE;
      it.idx   = idx[IDX_W-1:0];
      it.etime = tv;
      it.qtime = {$urandom, $urandom};
      if (idx < TABLE_DEPTH) plan_tbl[idx] = tv;
      pending_q.push_back(it);
   endtask

   task automatic queue_query(logic [QUERY_W-1:0] qt);
      req_item_type it;
      it.op    = OP_QUERY;
      it.idx   = $urandom;
      it.etime = {$urandom, $urandom};
      it.qtime = qt;
      pending_q.push_back(it);
   endtask

   // wait until the block has nothing left to do
   task automatic drain_all();
      while (pending_q.size() != 0 || weight_q.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_table(tbl_kind_type kind);
      logic [63:0]  x, step;
      int unsigned  m, i;
      m    = eff_slots() + 2;
      step = {32'd0, cfg_period} / (m - 1);
      if (step == 0) step = 1;
      x = (kind == TK_OFFSET) ? {32'd0, $urandom} % (step + 1) : 64'd0;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         if (i >= m || kind == TK_RANDOM) begin
            queue_write(i, {$urandom, $urandom});
         end else begin
            if (i > 0 && !(kind == TK_REPEAT && $urandom_range(0, 3) == 0))
               x = x + (step * $urandom_range(50, 150)) / 100;
            if (x > TIME_MAX) x = TIME_MAX;
            queue_write(i, x[TIME_W-1:0]);
         end
      end
   endtask

   function automatic tbl_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) return TK_ASCEND;
      if (r < 14) return TK_OFFSET;
      if (r < 17) return TK_RANDOM;
      return TK_REPEAT;
   endfunction

   function automatic logic [QUERY_W-1:0] rand_query();
      logic [63:0] raw;
      longint      p, k, r;
      int unsigned m;
      raw = {$urandom, $urandom};
      p   = longint'({32'd0, cfg_period});
      m   = eff_slots() + 2;
      k   = longint'($urandom_range(0, 40)) - 20;
      r   = (p != 0) ? longint'({32'd0, $urandom} % p) : longint'($urandom);
      case ($urandom_range(0, 9))
         0: return raw[QUERY_W-1:0];
         1: begin
            r   = k * p + longint'({31'd0, plan_tbl[$urandom_range(0, m - 1)]});
            raw = r;
            return raw[QUERY_W-1:0];
         end
         2: begin
            case ($urandom_range(0, 5))
               0: return {1'b0, {(QUERY_W-1){1'b1}}};
               1: return {1'b1, {(QUERY_W-1){1'b0}}};
               2: return '0;
               3: return '1;
               4: begin raw = p; return raw[QUERY_W-1:0]; end
               default: begin raw = -p; return raw[QUERY_W-1:0]; end
            endcase
         end
         default: begin
            raw = k * p + r;
            return raw[QUERY_W-1:0];
         end
      endcase
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] slot_set [NUM_PHASES];
      logic [CSR_DATA_W-1:0] per_set  [NUM_PHASES];
      int                    ph, cnt, sel, idx;
      logic [63:0]           v;

      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_now[i]  = '0;
         plan_tbl[i] = '0;
      end
      for (int i = 0; i < 4; i++) st_cnt[i] = 0;

      slot_set = '{12, 1, 16, 0, 31, 5, 17, 2, 8, 16, 3, 12};
      per_set  = '{65536, 1, 32'hFFFF_FFFF, 0, 65536, $urandom, $urandom_range(1000, 200000),
                   1000, 32'hFFFF_FFFF, $urandom, 1, 65536};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, table 0, 5000, ... 65000 over one period
      for (int i = 0; i < 14; i++) queue_write(i, i * 5000);
      queue_write(31, TIME_MAX);
      queue_query(0);
      queue_query(2500);
      queue_query(65000);
      queue_query(65535);
      queue_query({1'b0, {(QUERY_W-1){1'b1}}});
      queue_query({1'b1, {(QUERY_W-1){1'b0}}});
      queue_query(-48'sd188108);
      // time below the first entry
      queue_write(0, 100);
      queue_query(50);
      queue_write(0, 0);
      // last interval collapsed to zero width
      queue_write(12, 65000);
      queue_query(65000);
      queue_write(12, 60000);

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         drain_all();
         // upper bits of the slot count are don't-care
         csr_write(CSR_NUM_SLOTS, ($urandom & ~32'h1F) | slot_set[ph]);
         csr_write(CSR_PERIOD, per_set[ph]);
         load_table(TK_ASCEND);
         if (ph == 2) long_hold_go = 1'b1;
         cnt = 0;
         while (cnt < PHASE_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 2) begin
               load_table(pick_kind());
               cnt += TABLE_DEPTH;
            end else if (sel < 8) begin
               idx = $urandom_range(0, TABLE_DEPTH - 1);
               if ($urandom_range(0, 2) == 0) v = {$urandom, $urandom};
               else v = plan_tbl[idx] + $urandom_range(0, 64);
               if (v > TIME_MAX) v = TIME_MAX;
               queue_write(idx, v[TIME_W-1:0]);
               cnt++;
            end else if (sel < 11) begin
               // beyond the table: dropped by the block
               queue_write($urandom_range(TABLE_DEPTH, 31), {$urandom, $urandom});
            end else begin
               queue_query(rand_query());
               cnt++;
            end
         end
      end

      drain_all();
      $display("covered %0d table writes and %0d queries over %0d register settings",
               n_writes, n_queries, NUM_PHASES + 1);
      $display("status seen: ok %0d, below %0d, above %0d, zero width %0d",
               st_cnt[ST_OK], st_cnt[ST_BELOW], st_cnt[ST_ABOVE], st_cnt[ST_ZERO]);
      if (errors == 0 && weight_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
